>>> sv/ssc_pkg.sv
// Shared types and constants of the speed sensor conditioner.
`default_nettype none
package ssc_pkg;

    localparam int SPEED_W    = 16;
    localparam int AFS_W      = 12;
    localparam int DEB_W      = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int STEP_W     = $clog2(SPEED_W + 1);

    localparam int WINDOW_SIZE_DEF = 8;
    localparam int SAMPLE_BITS_DEF = 12;

    localparam logic [SPEED_W-1:0] SFS_RST   = 16'd2500;
    localparam logic [AFS_W-1:0]   AFS_RST   = 12'd4095;
    localparam logic [SPEED_W-1:0] FSPD_RST  = 16'd3000;
    localparam logic [DEB_W-1:0]   DEB_RST   = 8'd3;
    localparam logic [SPEED_W-1:0] SPEED_MAX = 16'hFFFF;

    typedef enum logic [1:0] {
        MODE_NONE   = 2'd0,
        MODE_SILENT = 2'd1,
        MODE_RANGE  = 2'd2
    } t_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SPEED_FS = 2'd0,
        CFG_ADC_FS   = 2'd1,
        CFG_FAULT_SP = 2'd2,
        CFG_DEBOUNCE = 2'd3
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_AVG,
        ST_MUL,
        ST_SCL_GO,
        ST_SCL_WAIT,
        ST_OUT
    } t_state;

endpackage
`default_nettype wire

>>> sv/ssc_cell.sv
// One window cell: holds a sample and passes it to the next cell.
`default_nettype none
module ssc_cell #(
    parameter int SAMPLE_BITS = ssc_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_load,
    input  wire logic                   i_shift,
    input  wire logic [SAMPLE_BITS-1:0] i_fill,
    input  wire logic [SAMPLE_BITS-1:0] i_prev,
    output logic      [SAMPLE_BITS-1:0] o_sample
);

    logic [SAMPLE_BITS-1:0] r_sample;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_sample <= i_fill;
        end else if (i_shift) begin
            r_sample <= i_prev;
        end
    end

    assign o_sample = r_sample;

endmodule
`default_nettype wire

>>> sv/ssc_div.sv
// Serial restoring divider, one quotient bit per cycle.
`default_nettype none
module ssc_div (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [ssc_pkg::AFS_W-1:0]     i_den,
    input  wire logic [ssc_pkg::AFS_W-1:0]     i_rem,
    input  wire logic [ssc_pkg::SPEED_W-1:0]   i_low,
    input  wire logic [ssc_pkg::STEP_W-1:0]    i_steps,
    output logic                               o_busy,
    output logic      [ssc_pkg::SPEED_W-1:0]   o_quo
);

    localparam int DW = ssc_pkg::AFS_W;
    localparam int QW = ssc_pkg::SPEED_W;

    logic              r_busy;
    logic [ssc_pkg::STEP_W-1:0] r_cnt;
    logic [DW-1:0]     r_rem;
    logic [DW-1:0]     r_den;
    logic [QW-1:0]     r_quo;

    logic [DW:0]       w_trial;
    logic [DW:0]       w_diff;
    logic              w_ge;
    logic [DW-1:0]     n_rem;

    always_comb begin
        w_trial = {r_rem, r_quo[QW-1]};
        w_diff  = w_trial - {1'b0, r_den};
        w_ge    = (w_trial >= {1'b0, r_den});
        n_rem   = w_ge ? w_diff[DW-1:0] : w_trial[DW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= i_steps;
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == ssc_pkg::STEP_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_rem;
            r_den <= i_den;
            r_quo <= i_low;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= {r_quo[QW-2:0], w_ge};
        end
    end

    assign o_busy = r_busy;
    assign o_quo  = r_quo;

endmodule
`default_nettype wire

>>> sv/ssc_btn.sv
// Button debounce and fault mode stepping.
`default_nettype none
module ssc_btn (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_step,
    input  wire logic                      i_pressed,
    input  wire logic [ssc_pkg::DEB_W-1:0] i_debounce,
    output ssc_pkg::t_mode                 o_mode
);

    logic [ssc_pkg::DEB_W-1:0] r_count;
    logic                      r_latched;
    ssc_pkg::t_mode            r_mode;
    ssc_pkg::t_mode            n_mode;

    always_comb begin
        case (r_mode)
            ssc_pkg::MODE_NONE:   n_mode = ssc_pkg::MODE_SILENT;
            ssc_pkg::MODE_SILENT: n_mode = ssc_pkg::MODE_RANGE;
            default:              n_mode = ssc_pkg::MODE_NONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_latched <= 1'b0;
            r_mode    <= ssc_pkg::MODE_NONE;
        end else if (i_step) begin
            if (!i_pressed) begin
                r_count   <= '0;
                r_latched <= 1'b0;
            end else if (r_count < i_debounce) begin
                r_count <= r_count + 1'b1;
            end else if (!r_latched) begin
                r_latched <= 1'b1;
                r_mode    <= n_mode;
            end
        end
    end

    assign o_mode = r_mode;

endmodule
`default_nettype wire

>>> sv/speed_sensor_conditioner_core.sv
// Top level of the speed sensor conditioner.
//
// Input channel (i_in_valid / o_in_stall) carries one item per tick: the ADC
// sample, its ok flag and the fault button level. Output channel
// (o_out_valid / i_out_stall) returns exactly one result item per input item.
// The configuration channel (i_cfg_valid / o_cfg_ready) writes the four
// registers by index; write only while no item is in flight.
// After an item is accepted it passes the states AVG (averaging only), MUL,
// SCL_GO, SCL_WAIT and OUT; the first good sample and a failed read skip
// AVG. The speed scaling uses the serial divider, one quotient bit per cycle.
// A scaled speed that saturates skips the divider and SCL_WAIT.
// One item is worked on at a time; the next is taken once the result sits
// in the output register, even while that result is still stalled.
// WINDOW_SIZE must be a power of two, which the block does not check; the
// average is a shift of the window sum. Reset clears the window sum, the
// fault mode and the debounce state, and loads the configuration reset
// values. A stalled result holds until taken.
`default_nettype none
module speed_sensor_conditioner_core #(
    parameter int WINDOW_SIZE = ssc_pkg::WINDOW_SIZE_DEF,
    parameter int SAMPLE_BITS = ssc_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_stall,
    input  wire logic [SAMPLE_BITS-1:0]            i_adc_sample,
    input  wire logic                              i_adc_ok,
    input  wire logic                              i_button_pressed,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_stall,
    output logic                                   o_send_frame,
    output logic      [ssc_pkg::SPEED_W-1:0]       o_speed_x10,
    output logic      [SAMPLE_BITS-1:0]            o_filtered_adc,
    output logic                                   o_fault_injected,
    output logic                                   o_adc_error,
    output logic      [1:0]                        o_fault_mode,
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [ssc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [ssc_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int SW     = ssc_pkg::SPEED_W;
    localparam int AW     = ssc_pkg::AFS_W;
    localparam int SUM_W  = SAMPLE_BITS + $clog2(WINDOW_SIZE);
    localparam int NUM_W  = SAMPLE_BITS + SW + 1;
    localparam int HI_W   = NUM_W - SW;
    localparam int CMP_W  = (HI_W > AW) ? HI_W : AW;

    // configuration
    logic [SW-1:0]                r_sfs;
    logic [AW-1:0]                r_afs;
    logic [SW-1:0]                r_fspd;
    logic [ssc_pkg::DEB_W-1:0]    r_deb;

    // control and datapath
    ssc_pkg::t_state              r_state;
    ssc_pkg::t_state              n_state;
    logic [SUM_W-1:0]             r_sum;
    logic [SAMPLE_BITS-1:0]       r_filt;
    logic                         r_primed;
    logic                         r_err;
    logic [NUM_W-1:0]             r_num;
    logic                         r_sat;

    logic                         r_out_valid;
    logic                         r_send;
    logic [SW-1:0]                r_speed;
    logic [SAMPLE_BITS-1:0]       r_out_filt;
    logic                         r_inj;
    logic                         r_out_err;
    logic [1:0]                   r_out_mode;

    logic                         w_acc;
    logic                         w_load;
    logic                         w_shift;
    logic [SAMPLE_BITS-1:0]       w_tap [WINDOW_SIZE];
    logic [SAMPLE_BITS-1:0]       w_oldest;
    ssc_pkg::t_mode               w_mode;

    logic [HI_W-1:0]              w_hi;
    logic                         w_sat;
    logic                         w_div_start;
    logic [AW-1:0]                w_div_den;
    logic [AW-1:0]                w_div_rem;
    logic [SW-1:0]                w_div_low;
    logic [ssc_pkg::STEP_W-1:0]   w_div_steps;
    logic                         w_div_busy;
    logic [SW-1:0]                w_div_quo;
    logic                         w_out_free;
    logic                         w_out_load;
    logic [SW-1:0]                w_speed;

    // configuration writes
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sfs  <= ssc_pkg::SFS_RST;
            r_afs  <= ssc_pkg::AFS_RST;
            r_fspd <= ssc_pkg::FSPD_RST;
            r_deb  <= ssc_pkg::DEB_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (ssc_pkg::t_cfg_idx'(i_cfg_index))
                ssc_pkg::CFG_SPEED_FS: r_sfs  <= i_cfg_data;
                ssc_pkg::CFG_ADC_FS:   r_afs  <= i_cfg_data[AW-1:0];
                ssc_pkg::CFG_FAULT_SP: r_fspd <= i_cfg_data;
                ssc_pkg::CFG_DEBOUNCE: r_deb  <= i_cfg_data[ssc_pkg::DEB_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_in_stall = (r_state != ssc_pkg::ST_IDLE);
    assign w_acc      = i_in_valid && !o_in_stall;
    assign w_load     = w_acc && i_adc_ok && !r_primed;
    assign w_shift    = w_acc && i_adc_ok && r_primed;

    // window cells
    for (genvar g = 0; g < WINDOW_SIZE; g++) begin : g_cell
        if (g == 0) begin : g_head
            ssc_cell #(.SAMPLE_BITS(SAMPLE_BITS)) u_cell (
                .i_clk    (i_clk),
                .i_load   (w_load),
                .i_shift  (w_shift),
                .i_fill   (i_adc_sample),
                .i_prev   (i_adc_sample),
                .o_sample (w_tap[g])
            );
        end else begin : g_body
            ssc_cell #(.SAMPLE_BITS(SAMPLE_BITS)) u_cell (
                .i_clk    (i_clk),
                .i_load   (w_load),
                .i_shift  (w_shift),
                .i_fill   (i_adc_sample),
                .i_prev   (w_tap[g-1]),
                .o_sample (w_tap[g])
            );
        end
    end

    assign w_oldest = w_tap[WINDOW_SIZE-1];

    ssc_btn u_btn (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (w_acc),
        .i_pressed  (i_button_pressed),
        .i_debounce (r_deb),
        .o_mode     (w_mode)
    );

    ssc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_den   (w_div_den),
        .i_rem   (w_div_rem),
        .i_low   (w_div_low),
        .i_steps (w_div_steps),
        .o_busy  (w_div_busy),
        .o_quo   (w_div_quo)
    );

    assign w_hi  = r_num[NUM_W-1:SW];
    assign w_sat = (CMP_W'(w_hi) >= CMP_W'(r_afs));

    assign w_out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        if (w_mode == ssc_pkg::MODE_RANGE) begin
            w_speed = r_fspd;
        end else if (r_sat) begin
            w_speed = ssc_pkg::SPEED_MAX;
        end else begin
            w_speed = w_div_quo;
        end
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ssc_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and divider control
    always_comb begin
        n_state     = r_state;
        w_div_start = 1'b0;
        w_div_den   = r_afs;
        w_div_rem   = AW'(w_hi);
        w_div_low   = r_num[SW-1:0];
        w_div_steps = ssc_pkg::STEP_W'(SW);
        w_out_load  = 1'b0;
        case (r_state)
            ssc_pkg::ST_IDLE: begin
                if (w_acc) begin
                    n_state = w_shift ? ssc_pkg::ST_AVG : ssc_pkg::ST_MUL;
                end
            end
            ssc_pkg::ST_AVG: begin
                n_state = ssc_pkg::ST_MUL;
            end
            ssc_pkg::ST_MUL: begin
                n_state = ssc_pkg::ST_SCL_GO;
            end
            ssc_pkg::ST_SCL_GO: begin
                w_div_start = !w_sat;
                n_state     = w_sat ? ssc_pkg::ST_OUT : ssc_pkg::ST_SCL_WAIT;
            end
            ssc_pkg::ST_SCL_WAIT: begin
                if (!w_div_busy) begin
                    n_state = ssc_pkg::ST_OUT;
                end
            end
            ssc_pkg::ST_OUT: begin
                if (w_out_free) begin
                    w_out_load = 1'b1;
                    n_state    = ssc_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = ssc_pkg::ST_IDLE;
            end
        endcase
    end

    // filter state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum    <= '0;
            r_filt   <= '0;
            r_primed <= 1'b0;
            r_err    <= 1'b0;
        end else begin
            if (w_acc) begin
                r_err <= !i_adc_ok;
            end
            if (w_load) begin
                r_sum    <= SUM_W'(SUM_W'(i_adc_sample) * SUM_W'(WINDOW_SIZE));
                r_filt   <= i_adc_sample;
                r_primed <= 1'b1;
            end else if (w_shift) begin
                r_sum <= r_sum - SUM_W'(w_oldest) + SUM_W'(i_adc_sample);
            end
            if (r_state == ssc_pkg::ST_AVG) begin
                r_filt <= r_sum[SUM_W-1 -: SAMPLE_BITS];
            end
        end
    end

    // scaling numerator and saturation
    always_ff @(posedge i_clk) begin
        if (r_state == ssc_pkg::ST_MUL) begin
            r_num <= NUM_W'(r_filt) * NUM_W'(r_sfs) + NUM_W'(r_afs >> 1);
        end
        if (r_state == ssc_pkg::ST_SCL_GO) begin
            r_sat <= w_sat;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_send     <= (w_mode != ssc_pkg::MODE_SILENT);
            r_speed    <= w_speed;
            r_out_filt <= r_filt;
            r_inj      <= (w_mode != ssc_pkg::MODE_NONE);
            r_out_err  <= r_err;
            r_out_mode <= w_mode;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_send_frame     = r_send;
    assign o_speed_x10      = r_speed;
    assign o_filtered_adc   = r_out_filt;
    assign o_fault_injected = r_inj;
    assign o_adc_error      = r_out_err;
    assign o_fault_mode     = r_out_mode;

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc |=> o_in_stall)
        else $error("input taken while previous item in progress");

    a_idle_div_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ssc_pkg::ST_IDLE) |-> !w_div_busy)
        else $error("divider busy while idle");

    a_inj_matches_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_fault_injected == (o_fault_mode != 2'(ssc_pkg::MODE_NONE))))
        else $error("fault flag disagrees with mode");

    a_silent_no_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_send_frame == (o_fault_mode != 2'(ssc_pkg::MODE_SILENT))))
        else $error("send flag disagrees with mode");

endmodule
`default_nettype wire
